// ===== src/cmws_pkg.sv =====
// ----------------------------------------------------------------------------
// cmws_pkg: shared types, codes and functions
// Request and register codes, the status bundle from the weight unit, and the
// popcount and trailing-zero helpers.
// ----------------------------------------------------------------------------
package cmws_pkg;

  localparam int unsigned VecW   = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned WtW    = 8;
  localparam int unsigned RcW    = 5;
  localparam int unsigned CfgW   = 8;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [0:0] CFG_THRESHOLD = 1'b1;

  // weight unit status toward the sequencer
  typedef struct packed {
    logic rejected;  // some stepped weight fell below threshold
    logic idle;      // no update or weight in flight
  } wu_status_t;

  // population count of a 128-bit word as a seven-level adder tree
  function automatic logic [WtW-1:0] pop128(input logic [VecW-1:0] x);
    logic [VecW-1:0] m1, m2, m4, m8, m16, m32, m64;
    logic [VecW-1:0] x1, x2, x4, x8, x16, x32, x64;
    m1  = {64{2'b01}};
    m2  = {32{4'b0011}};
    m4  = {16{8'h0F}};
    m8  = {8{16'h00FF}};
    m16 = {4{32'h0000_FFFF}};
    m32 = {2{64'h0000_0000_FFFF_FFFF}};
    m64 = {64'h0, {64{1'b1}}};
    x1  = (x   & m1)  + ((x   >> 1)  & m1);
    x2  = (x1  & m2)  + ((x1  >> 2)  & m2);
    x4  = (x2  & m4)  + ((x2  >> 4)  & m4);
    x8  = (x4  & m8)  + ((x4  >> 8)  & m8);
    x16 = (x8  & m16) + ((x8  >> 16) & m16);
    x32 = (x16 & m32) + ((x16 >> 32) & m32);
    x64 = (x32 & m64) + ((x32 >> 64) & m64);
    return x64[WtW-1:0];
  endfunction

  // index of the lowest set bit; zero for a zero word
  function automatic logic [4:0] ctz32(input logic [31:0] x);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/cmws_gen_mem.sv =====
// ----------------------------------------------------------------------------
// cmws_gen_mem: generator row store
// Two 64-bit banks, one per row half, one write and one registered read.
// ----------------------------------------------------------------------------
module cmws_gen_mem #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [RowW-1:0]              wr_row_i,
  input  logic                         wr_half_i,
  input  logic [cmws_pkg::HalfW-1:0]   wr_data_i,
  input  logic                         rd_en_i,
  input  logic [RowW-1:0]              rd_row_i,
  output logic [cmws_pkg::HalfW-1:0]   rd_lo_o,
  output logic [cmws_pkg::HalfW-1:0]   rd_hi_o
);

  logic [cmws_pkg::HalfW-1:0] lo_mem [MAX_ROWS];
  logic [cmws_pkg::HalfW-1:0] hi_mem [MAX_ROWS];
  logic [cmws_pkg::HalfW-1:0] rd_lo_q, rd_hi_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_half_i) begin
      lo_mem[wr_row_i] <= wr_data_i;
    end
    if (wr_en_i && wr_half_i) begin
      hi_mem[wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_lo_q <= lo_mem[rd_row_i];
      rd_hi_q <= hi_mem[rd_row_i];
    end
  end

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;

endmodule

// ===== src/cmws_weight_unit.sv =====
// ----------------------------------------------------------------------------
// cmws_weight_unit: shared XOR, popcount and compare unit
// Hold the working vector, fold in one row per step, count its weight and
// track the running minimum and the sticky reject flag.
// ----------------------------------------------------------------------------
module cmws_weight_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [cmws_pkg::VecW-1:0]    vec_i,
  input  logic                         step_i,
  input  logic [cmws_pkg::HalfW-1:0]   row_lo_i,
  input  logic [cmws_pkg::HalfW-1:0]   row_hi_i,
  input  logic [cmws_pkg::WtW-1:0]     threshold_i,
  output logic [cmws_pkg::WtW-1:0]     best_o,
  output cmws_pkg::wu_status_t         status_o
);

  logic [cmws_pkg::VecW-1:0] work_q;
  logic                      upd_q, first_q;
  logic [cmws_pkg::WtW-1:0]  wt_q;
  logic                      wt_v_q, wt_first_q;
  logic [cmws_pkg::WtW-1:0]  best_q;
  logic                      rej_q;

  // working vector: load the start vector or fold in one row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      upd_q   <= load_i | step_i;
      first_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      work_q <= vec_i;
    end else if (step_i) begin
      work_q <= work_q ^ {row_hi_i, row_lo_i};
    end
  end

  // weight of the vector just written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_v_q     <= 1'b0;
      wt_first_q <= 1'b0;
    end else begin
      wt_v_q     <= upd_q;
      wt_first_q <= first_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_q) begin
      wt_q <= cmws_pkg::pop128(work_q);
    end
  end

  // compare: the start weight seeds the minimum and is never checked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q  <= 1'b0;
      best_q <= '0;
    end else if (load_i) begin
      rej_q <= 1'b0;
    end else if (wt_v_q) begin
      if (wt_first_q) begin
        best_q <= wt_q;
      end else if (!rej_q) begin
        if (wt_q < threshold_i) begin
          rej_q <= 1'b1;
        end else if (wt_q < best_q) begin
          best_q <= wt_q;
        end
      end
    end
  end

  assign best_o            = best_q;
  assign status_o.rejected = rej_q;
  assign status_o.idle     = !upd_q && !wt_v_q;

endmodule

// ===== src/cmws_seq.sv =====
// ----------------------------------------------------------------------------
// cmws_seq: Gray-code step sequencer
// Count steps, pick row ctz(step) for each, and drain the unit at the end.
// ----------------------------------------------------------------------------
module cmws_seq #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        eval_i,
  input  logic [cmws_pkg::RcW-1:0]    row_count_i,
  input  cmws_pkg::wu_status_t        status_i,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [RowW-1:0]             rd_row_o,
  output logic                        step_o,
  output logic                        finish_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [MAX_ROWS-1:0] step_q, step_d;
  logic [MAX_ROWS-1:0] last_q, last_d;
  logic                rd_v_q;
  logic [5:0]          rc_ext, k;
  logic [MAX_ROWS-1:0] ones;
  logic [4:0]          low_idx;

  assign rc_ext  = {1'b0, row_count_i};
  assign k       = (rc_ext > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : rc_ext;
  assign ones    = '1;
  assign low_idx = cmws_pkg::ctz32(32'(step_q));
  assign rd_row_o = low_idx[RowW-1:0];

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    last_d   = last_q;
    rd_en_o  = 1'b0;
    finish_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (eval_i) begin
          last_d  = ~(ones << k);
          step_d  = MAX_ROWS'(1);
          state_d = (k == 6'd0) ? S_DRAIN : S_ISSUE;
        end
      end
      S_ISSUE: begin
        // stop early once a reject is seen; later steps cannot matter
        if (status_i.rejected) begin
          state_d = S_DRAIN;
        end else begin
          rd_en_o = 1'b1;
          step_d  = step_q + MAX_ROWS'(1);
          if (step_q == last_q) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && status_i.idle) begin
          finish_o = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    last_q <= last_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign step_o = rd_v_q;

endmodule

// ===== src/coset_min_weight_search.sv =====
// ----------------------------------------------------------------------------
// coset_min_weight_search: minimum-weight search over a code coset
// Store up to MAX_ROWS 128-bit generator rows and, per evaluate item, walk
// all 2^k row combinations in Gray-code order tracking the lowest weight.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  request  | start, busy          | req_type_i, row_index_i, half_select_i,
//           |                      | low_half_i, high_half_i
//  result   | done_o (strobe)      | min_weight_o, rejected_o
//  config   | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
//  An item is taken when start is high and busy is low. A load item writes
//  one row half in that edge and returns no result; busy stays low.
//  For an evaluate item with k = min(row_count, MAX_ROWS) the walk makes
//  2^k - 1 row reads, one per Gray step through the single read port of
//  the row store, then drains the read, XOR, popcount and compare stages
//  before the done_o strobe. With k = 0 there is no read and only the
//  start weight is counted and compared.
//  A reject ends the walk early.
//  done_o lasts one cycle and the receiver cannot stall it; a new item may
//  be taken in that same cycle.
//  Reset clears control state and the configuration registers; the row store holds
//  nothing until loaded and needs no clearing pass.
//
module coset_min_weight_search #(
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type_i,
  input  logic [3:0]                        row_index_i,
  input  logic                              half_select_i,
  input  logic [cmws_pkg::HalfW-1:0]        low_half_i,
  input  logic [cmws_pkg::HalfW-1:0]        high_half_i,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [cmws_pkg::CfgW-1:0]         cfg_wdata_i,
  // result channel
  output logic                              done_o,
  output logic [cmws_pkg::WtW-1:0]          min_weight_o,
  output logic                              rejected_o
);

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [cmws_pkg::RcW-1:0]   row_count_q;
  logic [cmws_pkg::WtW-1:0]   threshold_q;
  logic                       accept, eval_go, load_go;
  logic [5:0]                 row_ext;
  logic                       row_ok;
  logic                       rd_en, step, finish;
  logic [RowW-1:0]            rd_row;
  logic [cmws_pkg::HalfW-1:0] rd_lo, rd_hi;
  logic [cmws_pkg::WtW-1:0]   best;
  cmws_pkg::wu_status_t       wu_status;
  logic                       done_q, rejected_q;
  logic [cmws_pkg::WtW-1:0]   min_weight_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      threshold_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cmws_pkg::CFG_ROW_COUNT: row_count_q <= cfg_wdata_i[cmws_pkg::RcW-1:0];
        cmws_pkg::CFG_THRESHOLD: threshold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // split accepted items; drop loads to rows past the store
  assign accept  = start && !busy;
  assign eval_go = accept && (req_type_i == cmws_pkg::REQ_EVAL);
  assign row_ext = {2'b00, row_index_i};
  assign row_ok  = (row_ext < 6'(MAX_ROWS));
  assign load_go = accept && (req_type_i == cmws_pkg::REQ_LOAD) && row_ok;

  cmws_gen_mem #(
    .MAX_ROWS (MAX_ROWS),
    .RowW     (RowW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_go),
    .wr_row_i  (row_ext[RowW-1:0]),
    .wr_half_i (half_select_i),
    .wr_data_i (low_half_i),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_lo_o   (rd_lo),
    .rd_hi_o   (rd_hi)
  );

  cmws_seq #(
    .MAX_ROWS (MAX_ROWS),
    .RowW     (RowW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eval_i      (eval_go),
    .row_count_i (row_count_q),
    .status_i    (wu_status),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_row_o    (rd_row),
    .step_o      (step),
    .finish_o    (finish)
  );

  cmws_weight_unit u_wu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (eval_go),
    .vec_i       ({high_half_i, low_half_i}),
    .step_i      (step),
    .row_lo_i    (rd_lo),
    .row_hi_i    (rd_hi),
    .threshold_i (threshold_q),
    .best_o      (best),
    .status_o    (wu_status)
  );

  // result register: a reject reports weight zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      min_weight_q <= wu_status.rejected ? '0 : best;
      rejected_q   <= wu_status.rejected;
    end
  end

  assign done_o       = done_q;
  assign min_weight_o = min_weight_q;
  assign rejected_o   = rejected_q;

endmodule

// ===== src/cmws_checker.sv =====
// ----------------------------------------------------------------------------
// cmws_checker: port-level checks for the search block
// Watch request, busy and result ports over time.
// ----------------------------------------------------------------------------
module cmws_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         req_type_i,
  input logic                         done_o,
  input logic [cmws_pkg::WtW-1:0]     min_weight_o,
  input logic                         rejected_o
);

  // a result only shows once the search is over
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted evaluate item occupies the block
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == cmws_pkg::REQ_EVAL) |=> (busy && !done_o))
    else $error("evaluate item did not start a search");

  // a load item gives no result and leaves the block free
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == cmws_pkg::REQ_LOAD) |=> (!busy && !done_o))
    else $error("load item disturbed the block");

  // a rejected result reports weight zero
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rejected_o) |-> (min_weight_o == '0))
    else $error("rejected result with nonzero weight");

  // a weight never exceeds the vector length
  a_wt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (min_weight_o <= cmws_pkg::WtW'(cmws_pkg::VecW)))
    else $error("weight out of range");

endmodule

bind coset_min_weight_search cmws_checker u_cmws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_type_i   (req_type_i),
  .done_o       (done_o),
  .min_weight_o (min_weight_o),
  .rejected_o   (rejected_o)
);

// ===== verif/coset_min_weight_search_tb.sv =====
// ----------------------------------------------------------------------------
// coset_min_weight_search_tb: self-checking bench for the coset weight search
// Load generator rows, sweep row count and threshold, and check every
// evaluate result against a cycle-free Gray-code walk kept in a scoreboard.
// ----------------------------------------------------------------------------
module coset_min_weight_search_tb;

  import cmws_pkg::*;

  localparam int unsigned MAX_ROWS      = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;   // done strobe trails by four stages
  localparam int unsigned RAND_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS   = 10;
  localparam int unsigned REPORT_LIMIT  = 10;

  // one request item as it sits on the request ports
  typedef struct packed {
    logic             req_type;
    logic [3:0]       row_index;
    logic             half_select;
    logic [HalfW-1:0] low_half;
    logic [HalfW-1:0] high_half;
  } coset_req_t;

  // one result item
  typedef struct packed {
    logic [WtW-1:0] min_weight;
    logic           rejected;
  } weight_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow row store and registers, walk the coset on every
  // accepted evaluate item and queue the expected weight.
  // --------------------------------------------------------------------------
  class weight_scoreboard;
    logic [HalfW-1:0] rows [0:2*MAX_ROWS-1];
    logic [RcW-1:0]   row_count;
    logic [WtW-1:0]   threshold;
    weight_result_t   pending_weights [$];
    int unsigned      mismatches;

    function new();
      foreach (rows[i]) rows[i] = '0;
      row_count  = '0;
      threshold  = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [CfgW-1:0] data);
      if (idx == CFG_ROW_COUNT) begin
        row_count = data[RcW-1:0];
      end else begin
        threshold = data;
      end
    endfunction

    // Walk all 2^k row combinations in Gray order; bail out on the first
    // stepped weight under the threshold. The starting weight only seeds
    // the minimum and is never held against the threshold.
    function weight_result_t search_coset(logic [VecW-1:0] start_vec);
      weight_result_t   res;
      logic [VecW-1:0]  work;
      logic [16:0]      step;
      logic [16:0]      span;
      int unsigned      k;
      int unsigned      r;
      logic [WtW-1:0]   w;
      logic [WtW-1:0]   best;
      bit               hit_floor;
      k         = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
      span      = 17'(1) << k;
      work      = start_vec;
      best      = WtW'($countones(start_vec));
      hit_floor = 1'b0;
      for (step = 17'd1; step < span && !hit_floor; step++) begin
        r = 0;
        while (!step[r]) r++;
        work ^= {rows[2*r+1], rows[2*r]};
        w = WtW'($countones(work));
        if (w < threshold) begin
          hit_floor = 1'b1;
        end else if (w < best) begin
          best = w;
        end
      end
      res.min_weight = hit_floor ? '0 : best;
      res.rejected   = hit_floor;
      return res;
    endfunction

    // note an accepted item: loads update the shadow store, evaluates
    // queue their expected result
    function void note_item(coset_req_t it);
      if (it.req_type == REQ_LOAD) begin
        if (it.row_index < MAX_ROWS) rows[2*it.row_index + it.half_select] = it.low_half;
      end else begin
        pending_weights.push_back(search_coset({it.high_half, it.low_half}));
      end
    endfunction

    function void check_result(logic [WtW-1:0] mw, logic rej);
      weight_result_t exp_res;
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: min_weight %0d rejected %0b", mw, rej);
        return;
      end
      exp_res = pending_weights.pop_front();
      if (mw !== exp_res.min_weight || rej !== exp_res.rejected) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: expected min_weight %0d rejected %0b, got %0d %0b",
                   exp_res.min_weight, exp_res.rejected, mw, rej);
      end
    endfunction

    function int unsigned outstanding();
      return pending_weights.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its ports. Every input holds a known value from
  // time zero.
  // --------------------------------------------------------------------------
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start         = 1'b0;
  logic             busy;
  logic             req_type_i    = REQ_LOAD;
  logic [3:0]       row_index_i   = '0;
  logic             half_select_i = 1'b0;
  logic [HalfW-1:0] low_half_i    = '0;
  logic [HalfW-1:0] high_half_i   = '0;
  logic             cfg_we_i      = 1'b0;
  logic [0:0]       cfg_index_i   = CFG_ROW_COUNT;
  logic [CfgW-1:0]  cfg_wdata_i   = '0;
  logic             done_o;
  logic [WtW-1:0]   min_weight_o;
  logic             rejected_o;

  int unsigned      cycle_count;

  weight_scoreboard coset_check;

  coset_min_weight_search #(
    .MAX_ROWS(MAX_ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .row_index_i   (row_index_i),
    .half_select_i (half_select_i),
    .low_half_i    (low_half_i),
    .high_half_i   (high_half_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .min_weight_o  (min_weight_o),
    .rejected_o    (rejected_o)
  );

  // 8-unit clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample results at the rising edge; inputs only move on the falling one,
  // so what is read here is the value held through the cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) coset_check.check_result(min_weight_o, rejected_o);
  end

  // Guard against a hang: end the run as failed past the cycle limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one item and hold it until the block takes it (start high,
  // busy low at a rising edge).
  task automatic send_item(input coset_req_t it);
    @(negedge clk_i);
    start         <= 1'b1;
    req_type_i    <= it.req_type;
    row_index_i   <= it.row_index;
    half_select_i <= it.half_select;
    low_half_i    <= it.low_half;
    high_half_i   <= it.high_half;
    do @(posedge clk_i); while (busy);
    coset_check.note_item(it);
  endtask

  // drop start; n sets how long it stays low
  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Stop sending, wait for every queued result, then let the pipeline drain.
  task automatic settle();
    hold_off(1);
    while (coset_check.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only call while the block is idle.
  task automatic configure(input logic [CfgW-1:0] rc, input logic [CfgW-1:0] th);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_wdata_i <= rc;
    @(posedge clk_i);
    coset_check.write_reg(CFG_ROW_COUNT, rc);
    @(negedge clk_i);
    cfg_index_i <= CFG_THRESHOLD;
    cfg_wdata_i <= th;
    @(posedge clk_i);
    coset_check.write_reg(CFG_THRESHOLD, th);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------

  // random word with a random density: plain, sparse, dense, or a solid rail
  function automatic logic [HalfW-1:0] shaped_word();
    logic [HalfW-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0:       return a & b & c;
      1:       return a | b | c;
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return a;
    endcase
  endfunction

  function automatic coset_req_t load_req(input logic [3:0] row, input logic half,
                                          input logic [HalfW-1:0] data);
    coset_req_t it;
    it.req_type    = REQ_LOAD;
    it.row_index   = row;
    it.half_select = half;
    it.low_half    = data;
    it.high_half   = {$urandom, $urandom};   // ignored on a load
    return it;
  endfunction

  function automatic coset_req_t eval_req(input logic [HalfW-1:0] lo,
                                          input logic [HalfW-1:0] hi);
    coset_req_t it;
    it.req_type    = REQ_EVAL;
    it.row_index   = 4'($urandom_range(0, 15));  // ignored on an evaluate
    it.half_select = 1'($urandom_range(0, 1));
    it.low_half    = lo;
    it.high_half   = hi;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    coset_req_t     it;
    logic [CfgW-1:0] rc, th;
    bit             quiet;

    coset_check = new();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no rows in use, so the starting weight comes straight back,
    // even with a threshold above any weight.
    configure(8'd0, 8'd129);
    send_item(eval_req('0, '0));
    send_item(eval_req('1, '1));
    send_item(eval_req('1, '0));
    send_item(eval_req('0, '1));

    // rows 0, 1 and 15 with solid and striped halves
    send_item(load_req(4'd0, 1'b0, '1));
    send_item(load_req(4'd0, 1'b1, '1));
    send_item(load_req(4'd1, 1'b0, {32{2'b10}}));
    send_item(load_req(4'd1, 1'b1, '0));
    send_item(load_req(4'd15, 1'b0, '0));
    send_item(load_req(4'd15, 1'b1, '1));
    settle();

    // two rows, no floor: minimum over the whole coset
    configure(8'd2, 8'd0);
    send_item(eval_req('0, '0));
    send_item(eval_req('1, '1));
    settle();

    // threshold above 128: the first step rejects
    configure(8'd2, 8'd129);
    send_item(eval_req({$urandom, $urandom}, {$urandom, $urandom}));
    settle();

    // one row, mid threshold: one pass, one reject
    configure(8'd1, 8'd64);
    send_item(eval_req('0, '0));
    send_item(eval_req('1, '1));
    settle();

    // Fill every row half so any row count is legal from here on.
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int h = 0; h < 2; h++) begin
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
        send_item(load_req(4'(r), 1'(h), shaped_word()));
      end
    end
    settle();

    // Full-depth walks: all rows, then a row count past the limit that
    // saturates, then an instant reject at full depth.
    configure(8'd16, 8'd0);
    send_item(eval_req(shaped_word(), shaped_word()));
    settle();
    configure(8'd31, 8'd0);
    send_item(eval_req(shaped_word(), shaped_word()));
    settle();
    configure(8'd16, 8'd129);
    send_item(eval_req(shaped_word(), shaped_word()));
    settle();

    // Random phases with small row counts; the last one runs without gaps.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      quiet = (phase == RAND_PHASES - 1);
      if (phase == 0) rc = 8'd0;
      else if (phase == 1) rc = 8'd6;
      else rc = 8'($urandom_range(0, 6));
      case ($urandom_range(0, 5))
        0:       th = 8'd0;
        1:       th = 8'd129;
        2:       th = 8'($urandom_range(0, 129));
        default: th = 8'($urandom_range(10, 70));
      endcase
      configure(rc, th);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
        // now and then wait out every queued result before the next item
        if (!quiet && $urandom_range(0, 14) == 0) settle();
        if ($urandom_range(0, 9) < 3) begin
          it = load_req(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), shaped_word());
        end else begin
          it = eval_req(shaped_word(), shaped_word());
        end
        send_item(it);
      end
      settle();
    end

    if (coset_check.mismatches == 0 && coset_check.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
